// ===== hw/rtl/cfafs_pkg.sv =====
// ----------------------------------------------------------------------------
// Coarse/fine autofocus search package
// Shared types and constants for the autofocus search block: command codes,
// search phases, the queue entry, the result and the configuration bundle.
// ----------------------------------------------------------------------------
package cfafs_pkg;

  localparam int STAT_W   = 24;  // width of one window statistic on the bus
  localparam int SUM_W    = 26;  // sum of three statistics
  localparam int FOCUS_W  = 24;
  localparam int STEP_W   = 16;
  localparam int COUNT_W  = 8;
  localparam int LIMIT_W  = 16;
  localparam int STH_W    = 25;
  localparam int LTH_W    = 22;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Fine pass starts this far above the coarse best focus.
  localparam int FINE_OFFSET = 10;

  // Division of a 24-bit value by five: multiply by ceil(2^26 / 5), shift by 26.
  localparam int DIV5_SHIFT = 26;
  localparam logic [DIV5_SHIFT-1:0] DIV5_MULT = 26'd13421773;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_COARSE_STEP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COARSE_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FINE_STEP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FINE_COUNT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FOCUS_LIMIT  = 3'd4;

  typedef enum logic [1:0] {
    CMD_SET         = 2'd0,
    CMD_SET_MEASURE = 2'd1,
    CMD_MEASURE     = 2'd2,
    CMD_DONE        = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_COARSE = 2'd1,
    PH_FINE   = 2'd2,
    PH_SETTLE = 2'd3
  } phase_t;

  typedef struct packed {
    logic [STEP_W-1:0]  coarse_step;
    logic [COUNT_W-1:0] coarse_count;
    logic [STEP_W-1:0]  fine_step;
    logic [COUNT_W-1:0] fine_count;
    logic [LIMIT_W-1:0] focus_limit;
  } cfg_t;

  // One classified beat as it waits in the queue.
  typedef struct packed {
    logic             is_stat;
    logic [SUM_W-1:0] sharp_sum;
    logic [SUM_W-1:0] lum_sum;
  } item_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [FOCUS_W-1:0] focus;
    logic [STH_W-1:0]   sharp_threshold;
    logic [LTH_W-1:0]   lum_threshold;
    logic               last;
  } result_t;

endpackage

// ===== hw/rtl/cfafs_front.sv =====
// ----------------------------------------------------------------------------
// Autofocus search front end
// Accepts input beats, masks the statistics to their used width, forms the
// sharpness and luminance sums and pushes the classified item to the queue.
// ----------------------------------------------------------------------------
module cfafs_front #(
  parameter int STAT_WIDTH = 24
) (
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [6*cfafs_pkg::STAT_W-1:0] in_tdata,
  input  logic                      in_tuser,
  input  logic                      q_full,
  output logic                      q_push,
  output cfafs_pkg::item_t          q_item
);

  localparam int SW = (STAT_WIDTH < cfafs_pkg::STAT_W) ? STAT_WIDTH : cfafs_pkg::STAT_W;
  localparam logic [cfafs_pkg::STAT_W-1:0] STAT_MASK =
      cfafs_pkg::STAT_W'((64'd1 << SW) - 64'd1);

  logic [cfafs_pkg::STAT_W-1:0] s_a, s_b, s_c, l_a, l_b, l_c;

  assign s_a = in_tdata[0*cfafs_pkg::STAT_W +: cfafs_pkg::STAT_W] & STAT_MASK;
  assign s_b = in_tdata[1*cfafs_pkg::STAT_W +: cfafs_pkg::STAT_W] & STAT_MASK;
  assign s_c = in_tdata[2*cfafs_pkg::STAT_W +: cfafs_pkg::STAT_W] & STAT_MASK;
  assign l_a = in_tdata[3*cfafs_pkg::STAT_W +: cfafs_pkg::STAT_W] & STAT_MASK;
  assign l_b = in_tdata[4*cfafs_pkg::STAT_W +: cfafs_pkg::STAT_W] & STAT_MASK;
  assign l_c = in_tdata[5*cfafs_pkg::STAT_W +: cfafs_pkg::STAT_W] & STAT_MASK;

  assign in_tready = ~q_full;
  assign q_push    = in_tvalid & ~q_full;

  always_comb begin
    q_item.is_stat   = in_tuser;
    q_item.sharp_sum = cfafs_pkg::SUM_W'(s_a) + cfafs_pkg::SUM_W'(s_b)
                     + cfafs_pkg::SUM_W'(s_c);
    q_item.lum_sum   = cfafs_pkg::SUM_W'(l_a) + cfafs_pkg::SUM_W'(l_b)
                     + cfafs_pkg::SUM_W'(l_c);
  end

endmodule

// ===== hw/rtl/cfafs_queue.sv =====
// ----------------------------------------------------------------------------
// Autofocus search item queue
// Small register FIFO between the front end and the sequencer.
// ----------------------------------------------------------------------------
module cfafs_queue #(
  parameter int WIDTH = 53,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head_data,
  output logic             not_empty,
  output logic             full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign not_empty = (count_r != '0);
  assign full      = (count_r == CNT_W'(DEPTH));
  assign do_push   = push & ~full;
  assign do_pop    = pop & not_empty;
  assign head_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hw/rtl/cfafs_back.sv =====
// ----------------------------------------------------------------------------
// Autofocus search sequencer
// Takes classified items from the queue, walks the coarse, fine and settle
// phases and loads each lens command into the output register.
// ----------------------------------------------------------------------------
module cfafs_back #(
  parameter int SETTLE_LIMIT = 30
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cfafs_pkg::cfg_t     cfg,
  input  logic                q_valid,
  input  cfafs_pkg::item_t    q_item,
  output logic                q_pop,
  input  logic                out_tready,
  output logic                out_tvalid,
  output cfafs_pkg::result_t  out_res
);

  localparam int CW = $clog2(SETTLE_LIMIT + 1);
  localparam int SUM_W = cfafs_pkg::SUM_W;
  localparam int FOCUS_W = cfafs_pkg::FOCUS_W;
  localparam int LIMIT_W = cfafs_pkg::LIMIT_W;

  cfafs_pkg::phase_t          phase_r, phase_nxt;
  logic [cfafs_pkg::COUNT_W-1:0] pos_r, pos_nxt;
  logic [FOCUS_W-1:0]         acc_r, acc_nxt;       // position times step
  logic [LIMIT_W-1:0]         base_r, base_nxt;     // fine sweep start
  logic [FOCUS_W-1:0]         best_focus_r, best_focus_nxt;
  logic [SUM_W-1:0]           best_sum_r, best_sum_nxt;
  logic [CW-1:0]              settle_r, settle_nxt;
  logic                       prev_close_r, prev_close_nxt;
  logic                       second_r, second_nxt; // second beat of a start
  logic                       out_valid_r, out_valid_nxt;
  cfafs_pkg::result_t         res_r, res_nxt;

  logic                       load_ok, emits, fire;
  logic [FOCUS_W-1:0]         acc_coarse_nxt, acc_fine_nxt;
  logic [FOCUS_W-1:0]         fine_cur, fine_next, cur_focus;
  logic                       take;
  logic [FOCUS_W-1:0]         nb_focus;
  logic [SUM_W-1:0]           nb_sum;
  logic [FOCUS_W:0]           sweep_raw;
  logic [LIMIT_W-1:0]         sweep;
  logic [SUM_W-1:0]           diff;
  logic [SUM_W+3:0]           diff10, best3;
  logic                       close, settle_done;
  logic [CW:0]                settle_inc;
  logic [49:0]                lum_prod;
  logic [cfafs_pkg::LTH_W-1:0] lum_q;

  // ---- datapath ----
  always_comb begin
    acc_coarse_nxt = acc_r + FOCUS_W'(cfg.coarse_step);
    acc_fine_nxt   = acc_r + FOCUS_W'(cfg.fine_step);
    fine_cur  = (acc_r >= FOCUS_W'(base_r)) ? '0
              : FOCUS_W'(base_r - acc_r[LIMIT_W-1:0]);
    fine_next = (acc_fine_nxt >= FOCUS_W'(base_r)) ? '0
              : FOCUS_W'(base_r - acc_fine_nxt[LIMIT_W-1:0]);
    cur_focus = (phase_r == cfafs_pkg::PH_FINE) ? fine_cur : acc_r;
    take      = q_item.sharp_sum > best_sum_r;
    nb_focus  = take ? cur_focus : best_focus_r;
    nb_sum    = take ? q_item.sharp_sum : best_sum_r;
    sweep_raw = {1'b0, nb_focus} + (FOCUS_W+1)'(cfafs_pkg::FINE_OFFSET);
    sweep     = (sweep_raw > (FOCUS_W+1)'(cfg.focus_limit)) ? cfg.focus_limit
              : sweep_raw[LIMIT_W-1:0];
    diff      = (q_item.sharp_sum >= best_sum_r) ? q_item.sharp_sum - best_sum_r
              : best_sum_r - q_item.sharp_sum;
    diff10    = {1'b0, diff, 3'b000} + {3'b000, diff, 1'b0};
    best3     = {3'b000, best_sum_r, 1'b0} + {4'b0000, best_sum_r};
    close     = diff10 < best3;
    settle_inc  = {1'b0, settle_r} + 1'b1;
    settle_done = ((settle_r != '0) && close && prev_close_r)
                || (settle_inc >= (CW+1)'(SETTLE_LIMIT));
    // lum / 20 = (lum / 4) / 5 by reciprocal multiplication.
    lum_prod  = 50'(q_item.lum_sum[SUM_W-1:2]) * 50'(cfafs_pkg::DIV5_MULT);
    lum_q     = lum_prod[cfafs_pkg::DIV5_SHIFT +: cfafs_pkg::LTH_W];
  end

  assign load_ok = ~out_valid_r | out_tready;
  assign emits   = ~(q_item.is_stat && (phase_r == cfafs_pkg::PH_IDLE));
  assign fire    = q_valid & (load_ok | ~emits);
  assign q_pop   = fire & ~(~q_item.is_stat & ~second_r);

  // ---- next phase ----
  always_comb begin
    phase_nxt = phase_r;
    if (fire) begin
      if (!q_item.is_stat) begin
        if (second_r) begin
          phase_nxt = cfafs_pkg::PH_COARSE;
        end
      end else begin
        unique case (phase_r)
          cfafs_pkg::PH_IDLE: begin
            phase_nxt = cfafs_pkg::PH_IDLE;
          end
          cfafs_pkg::PH_COARSE: begin
            if (pos_r >= cfg.coarse_count) begin
              phase_nxt = cfafs_pkg::PH_FINE;
            end
          end
          cfafs_pkg::PH_FINE: begin
            if (pos_r >= cfg.fine_count) begin
              phase_nxt = cfafs_pkg::PH_SETTLE;
            end
          end
          cfafs_pkg::PH_SETTLE: begin
            if (settle_done) begin
              phase_nxt = cfafs_pkg::PH_IDLE;
            end
          end
          default: phase_nxt = cfafs_pkg::PH_IDLE;
        endcase
      end
    end
  end

  // ---- state and result outputs ----
  always_comb begin
    pos_nxt        = pos_r;
    acc_nxt        = acc_r;
    base_nxt       = base_r;
    best_focus_nxt = best_focus_r;
    best_sum_nxt   = best_sum_r;
    settle_nxt     = settle_r;
    prev_close_nxt = prev_close_r;
    second_nxt     = second_r;
    out_valid_nxt  = out_valid_r & ~out_tready;
    res_nxt        = res_r;
    res_nxt.sharp_threshold = '0;
    res_nxt.lum_threshold   = '0;
    res_nxt.last            = 1'b1;
    res_nxt.cmd             = cfafs_pkg::CMD_SET_MEASURE;
    res_nxt.focus           = '0;

    if (fire && emits) begin
      out_valid_nxt = 1'b1;
    end

    if (fire) begin
      if (!q_item.is_stat) begin
        if (!second_r) begin
          res_nxt.cmd  = cfafs_pkg::CMD_SET;
          res_nxt.last = 1'b0;
          second_nxt   = 1'b1;
        end else begin
          second_nxt     = 1'b0;
          pos_nxt        = '0;
          acc_nxt        = '0;
          base_nxt       = '0;
          best_focus_nxt = '0;
          best_sum_nxt   = '0;
          settle_nxt     = '0;
          prev_close_nxt = 1'b0;
        end
      end else begin
        unique case (phase_r)
          cfafs_pkg::PH_IDLE: begin
            res_nxt = res_r;
          end
          cfafs_pkg::PH_COARSE: begin
            best_focus_nxt = nb_focus;
            best_sum_nxt   = nb_sum;
            if (pos_r < cfg.coarse_count) begin
              pos_nxt       = pos_r + 1'b1;
              acc_nxt       = acc_coarse_nxt;
              res_nxt.focus = acc_coarse_nxt;
            end else begin
              best_sum_nxt  = '0;
              base_nxt      = sweep;
              pos_nxt       = '0;
              acc_nxt       = '0;
              res_nxt.focus = FOCUS_W'(sweep);
            end
          end
          cfafs_pkg::PH_FINE: begin
            best_focus_nxt = nb_focus;
            best_sum_nxt   = nb_sum;
            if (pos_r < cfg.fine_count) begin
              pos_nxt       = pos_r + 1'b1;
              acc_nxt       = acc_fine_nxt;
              res_nxt.focus = fine_next;
            end else begin
              settle_nxt     = '0;
              prev_close_nxt = 1'b0;
              res_nxt.focus  = nb_focus;
            end
          end
          cfafs_pkg::PH_SETTLE: begin
            prev_close_nxt = close;
            settle_nxt     = settle_inc[CW-1:0];
            res_nxt.focus  = best_focus_r;
            if (settle_done) begin
              res_nxt.cmd             = cfafs_pkg::CMD_DONE;
              res_nxt.sharp_threshold = q_item.sharp_sum[SUM_W-1:1];
              res_nxt.lum_threshold   = lum_q;
            end else begin
              res_nxt.cmd = cfafs_pkg::CMD_MEASURE;
            end
          end
          default: res_nxt = res_r;
        endcase
      end
    end else begin
      res_nxt = res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= cfafs_pkg::PH_IDLE;
      pos_r        <= '0;
      acc_r        <= '0;
      base_r       <= '0;
      best_focus_r <= '0;
      best_sum_r   <= '0;
      settle_r     <= '0;
      prev_close_r <= 1'b0;
      second_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      pos_r        <= pos_nxt;
      acc_r        <= acc_nxt;
      base_r       <= base_nxt;
      best_focus_r <= best_focus_nxt;
      best_sum_r   <= best_sum_nxt;
      settle_r     <= settle_nxt;
      prev_close_r <= prev_close_nxt;
      second_r     <= second_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_res    = res_r;

endmodule

// ===== hw/rtl/coarse_fine_autofocus_search_top.sv =====
// ----------------------------------------------------------------------------
// Coarse/fine contrast-detect autofocus search
// Drives a lens through a coarse upward sweep, a fine downward sweep and a
// settle phase, and reports sharpness and luminance thresholds when done.
// ----------------------------------------------------------------------------
// A start beat (tuser 0) yields two result beats, set focus 0 and then set
// focus 0 and measure; each statistics beat (tuser 1) yields one result beat
// carrying the next lens command, except that statistics arriving while no
// search is running are dropped without a result. The front end forms the
// sharpness and luminance sums in the cycle a beat is accepted and writes
// them into a four-entry queue; the sequencer takes one queued beat per cycle
// while the output does not stall, and loads its command into the output
// register. Sustained rate is thus one statistics beat per cycle; a start
// beat stays at the queue head until both of its result beats have gone
// through the single output register. The input side keeps accepting while a
// result waits at the output until the queue fills. Configuration registers
// may only be written while the block is idle; they take effect for the next
// search.
// ----------------------------------------------------------------------------
module coarse_fine_autofocus_search_top #(
  parameter int SETTLE_LIMIT = 30,  // settle measurements before giving up
  parameter int STAT_WIDTH   = 24   // used low bits of each statistic
) (
  input  logic         clk,
  input  logic         rst_n,
  // Input stream.
  input  logic         in_tvalid,
  output logic         in_tready,
  // sharp_a[23:0], sharp_b[47:24], sharp_c[71:48],
  // lum_a[95:72], lum_b[119:96], lum_c[143:120]
  input  logic [143:0] in_tdata,
  input  logic         in_tuser,    // action: 0 start, 1 statistics
  // Result stream.
  output logic         out_tvalid,
  input  logic         out_tready,
  // focus[23:0], sharp_threshold[48:24], lum_threshold[70:49], zero [71]
  output logic [71:0]  out_tdata,
  output logic [1:0]   out_tuser,   // command
  output logic         out_tlast,
  // Configuration write port.
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_wdata
);

  localparam int Q_DEPTH = 4;

  cfafs_pkg::cfg_t    cfg_r, cfg_nxt;
  cfafs_pkg::item_t   push_item, head_item;
  cfafs_pkg::result_t res;
  logic               q_push, q_pop, q_full, q_valid;
  logic [$bits(cfafs_pkg::item_t)-1:0] head_bits;

  // Configuration registers; an index beyond the list is ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        cfafs_pkg::REG_COARSE_STEP:  cfg_nxt.coarse_step  = cfg_wdata;
        cfafs_pkg::REG_COARSE_COUNT: cfg_nxt.coarse_count = cfg_wdata[7:0];
        cfafs_pkg::REG_FINE_STEP:    cfg_nxt.fine_step    = cfg_wdata;
        cfafs_pkg::REG_FINE_COUNT:   cfg_nxt.fine_count   = cfg_wdata[7:0];
        cfafs_pkg::REG_FOCUS_LIMIT:  cfg_nxt.focus_limit  = cfg_wdata;
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.coarse_step  <= 16'd100;
      cfg_r.coarse_count <= 8'd10;
      cfg_r.fine_step    <= 16'd10;
      cfg_r.fine_count   <= 8'd20;
      cfg_r.focus_limit  <= 16'd1023;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  cfafs_front #(
    .STAT_WIDTH (STAT_WIDTH)
  ) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  cfafs_queue #(
    .WIDTH ($bits(cfafs_pkg::item_t)),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_item),
    .pop       (q_pop),
    .head_data (head_bits),
    .not_empty (q_valid),
    .full      (q_full)
  );

  assign head_item = cfafs_pkg::item_t'(head_bits);

  cfafs_back #(
    .SETTLE_LIMIT (SETTLE_LIMIT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_item     (head_item),
    .q_pop      (q_pop),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_res    (res)
  );

  assign out_tdata = {1'b0, res.lum_threshold, res.sharp_threshold, res.focus};
  assign out_tuser = res.cmd;
  assign out_tlast = res.last;

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// Autofocus search testbench
// Drives start and statistics beats into the coarse/fine autofocus search
// block under several register settings, predicts every lens command it
// should issue, and checks each result beat field by field against it.
// ----------------------------------------------------------------------------
module tb_top;
  import cfafs_pkg::*;

  localparam int SETTLE_LIMIT = 30;
  localparam int STAT_MAX     = 24'hFFFFFF;
  // A beat reaches the output through a four-entry queue and the output
  // register; this many quiet cycles cover beats that end with no result.
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 300000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [143:0] in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [71:0]  out_tdata;
  logic [1:0]   out_tuser;
  logic         out_tlast;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_index = '0;
  logic [15:0]  cfg_wdata = '0;

  coarse_fine_autofocus_search_top #(
    .SETTLE_LIMIT(SETTLE_LIMIT),
    .STAT_WIDTH  (24)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),   // sharp_a, sharp_b, sharp_c, lum_a, lum_b, lum_c
    .in_tuser  (in_tuser),   // action
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),  // focus, sharp_threshold, lum_threshold, pad bit
    .out_tuser (out_tuser),  // command
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  // --------------------------------------------------------------------------
  // Lens command predictor. It keeps its own copy of the search state and of
  // the registers, and turns every accepted beat into the lens commands that
  // the block must issue, in order, into lens_cmds.
  // --------------------------------------------------------------------------
  phase_t            search_phase;
  longint unsigned   pos_idx;      // position within the current sweep
  longint unsigned   sweep_top;    // fine pass start focus
  longint unsigned   peak_focus;
  longint unsigned   peak_sharp;
  int unsigned       settle_n;
  bit                was_close;
  cfg_t              lens_cfg;
  result_t           lens_cmds[$];

  // Run statistics, for the closing summary.
  int unsigned       counted_beats;
  int unsigned       ignored_beats;
  int unsigned       searches_done;
  int unsigned       restarts;
  int unsigned       settings_used;
  int unsigned       beats_checked;
  int unsigned       err_count;
  int unsigned       cycle_count;

  function automatic void reset_predictor();
    search_phase = PH_IDLE;
    pos_idx      = 0;
    sweep_top    = 0;
    peak_focus   = 0;
    peak_sharp   = 0;
    settle_n     = 0;
    was_close    = 1'b0;
    lens_cfg.coarse_step  = 16'd100;
    lens_cfg.coarse_count = 8'd10;
    lens_cfg.fine_step    = 16'd10;
    lens_cfg.fine_count   = 8'd20;
    lens_cfg.focus_limit  = 16'd1023;
  endfunction

  // The predictor clamps focus at the top of its 24-bit range.
  function automatic void queue_cmd(input cmd_t c, input longint unsigned f,
                                    input longint unsigned sth,
                                    input longint unsigned lth, input bit last);
    result_t r;
    r.cmd             = c;
    r.focus           = (f > STAT_MAX) ? 24'hFFFFFF : f[23:0];
    r.sharp_threshold = sth[24:0];
    r.lum_threshold   = lth[21:0];
    r.last            = last;
    lens_cmds.push_back(r);
  endfunction

  // The fine pass walks down from its start and stops at zero.
  function automatic longint unsigned fine_pos(input longint unsigned idx);
    longint unsigned dec;
    dec = idx * lens_cfg.fine_step;
    return (dec >= sweep_top) ? 64'd0 : sweep_top - dec;
  endfunction

  // Returns the number of result beats the accepted beat causes.
  function automatic int predict_commands(input logic act, input logic [143:0] data);
    longint unsigned sharp_sum, lum_sum, here, diff;
    bit near, halt;
    if (act == 1'b0) begin
      if (search_phase != PH_IDLE) restarts++;
      search_phase = PH_COARSE;
      pos_idx      = 0;
      sweep_top    = 0;
      peak_focus   = 0;
      peak_sharp   = 0;
      settle_n     = 0;
      was_close    = 1'b0;
      queue_cmd(CMD_SET, 0, 0, 0, 1'b0);
      queue_cmd(CMD_SET_MEASURE, 0, 0, 0, 1'b1);
      return 2;
    end
    sharp_sum = 64'(data[23:0]) + 64'(data[47:24]) + 64'(data[71:48]);
    lum_sum   = 64'(data[95:72]) + 64'(data[119:96]) + 64'(data[143:120]);
    case (search_phase)
      PH_COARSE: begin
        here = pos_idx * lens_cfg.coarse_step;
        if (here > STAT_MAX) here = STAT_MAX;
        if (sharp_sum > peak_sharp) begin
          peak_sharp = sharp_sum;
          peak_focus = here;
        end
        if (pos_idx < lens_cfg.coarse_count) begin
          pos_idx++;
          queue_cmd(CMD_SET_MEASURE, pos_idx * lens_cfg.coarse_step, 0, 0, 1'b1);
        end else begin
          // The fine maximum is tracked from scratch; the coarse best focus stays.
          peak_sharp = 0;
          sweep_top  = peak_focus + FINE_OFFSET;
          if (sweep_top > lens_cfg.focus_limit) sweep_top = lens_cfg.focus_limit;
          pos_idx      = 0;
          search_phase = PH_FINE;
          queue_cmd(CMD_SET_MEASURE, sweep_top, 0, 0, 1'b1);
        end
        return 1;
      end
      PH_FINE: begin
        here = fine_pos(pos_idx);
        if (sharp_sum > peak_sharp) begin
          peak_sharp = sharp_sum;
          peak_focus = here;
        end
        if (pos_idx < lens_cfg.fine_count) begin
          pos_idx++;
          queue_cmd(CMD_SET_MEASURE, fine_pos(pos_idx), 0, 0, 1'b1);
        end else begin
          search_phase = PH_SETTLE;
          settle_n     = 0;
          was_close    = 1'b0;
          queue_cmd(CMD_SET_MEASURE, peak_focus, 0, 0, 1'b1);
        end
        return 1;
      end
      PH_SETTLE: begin
        // "Within 0.3 of the fine maximum", exact in integers.
        diff = (sharp_sum > peak_sharp) ? sharp_sum - peak_sharp : peak_sharp - sharp_sum;
        near = (diff * 10) < (peak_sharp * 3);
        halt = (settle_n >= 1) && near && was_close;
        was_close = near;
        settle_n++;
        if (halt || settle_n >= SETTLE_LIMIT) begin
          search_phase = PH_IDLE;
          searches_done++;
          queue_cmd(CMD_DONE, peak_focus, sharp_sum >> 1, lum_sum / 20, 1'b1);
        end else begin
          queue_cmd(CMD_MEASURE, peak_focus, 0, 0, 1'b1);
        end
        return 1;
      end
      default: return 0;  // statistics with no search running are dropped
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  bit in_calm = 1'b0;   // a stretch with no gaps on the input side
  bit out_calm = 1'b0;  // a stretch with no stalls on the result side
  int ready_hold = 0;

  // Gap or stall length: mostly none or short, now and then long.
  function automatic int idle_span();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [143:0] pack_stats(input logic [23:0] sa, input logic [23:0] sb,
                                              input logic [23:0] sc, input logic [23:0] la,
                                              input logic [23:0] lb, input logic [23:0] lc);
    return {lc, lb, la, sc, sb, sa};
  endfunction

  // Statistics shaped by where the search stands: during settling most sums
  // land near the fine maximum so that both stop rules get exercised, and a
  // dark fine pass leaves the fine maximum at zero.
  function automatic logic [143:0] shaped_stats(input bit dark_fine);
    logic [23:0] sh_a, sh_b, sh_c, lu_a, lu_b, lu_c;
    longint unsigned target, third, span;
    int pick;
    pick = $urandom_range(0, 99);
    if (search_phase == PH_FINE && dark_fine) begin
      sh_a = '0;
      sh_b = '0;
      sh_c = '0;
    end else if (search_phase == PH_SETTLE && pick < 75) begin
      span   = peak_sharp * 2 / 5;
      target = peak_sharp - span + $urandom_range(0, 32'(2 * span));
      if (target > 3 * STAT_MAX) target = 3 * STAT_MAX;
      third = target / 3;
      sh_a  = third[23:0];
      sh_b  = third[23:0];
      sh_c  = (target - 2 * third > STAT_MAX) ? 24'hFFFFFF : 24'(target - 2 * third);
    end else if (pick < 88) begin
      sh_a = 24'($urandom_range(0, STAT_MAX));
      sh_b = 24'($urandom_range(0, STAT_MAX));
      sh_c = 24'($urandom_range(0, STAT_MAX));
    end else begin
      sh_a = 24'($urandom_range(0, 4095));
      sh_b = 24'($urandom_range(0, 4095));
      sh_c = 24'($urandom_range(0, 4095));
    end
    lu_a = 24'($urandom_range(0, STAT_MAX));
    lu_b = 24'($urandom_range(0, STAT_MAX));
    lu_c = ($urandom_range(0, 9) == 0) ? 24'hFFFFFF : 24'($urandom_range(0, STAT_MAX));
    return pack_stats(sh_a, sh_b, sh_c, lu_a, lu_b, lu_c);
  endfunction

  // Offers one beat after a random gap, holds it until the block takes it,
  // then predicts its results. Called and returning right after a rising edge.
  task automatic send_beat(input logic act, input logic [143:0] data);
    int gap;
    gap = in_calm ? 0 : idle_span();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= data;
    do begin
      @(posedge clk);
    end while (!in_tready);
    if (predict_commands(act, data) != 0) counted_beats++;
    else ignored_beats++;
    if ($urandom_range(0, 149) == 0) in_calm = !in_calm;
  endtask

  // Stops offering beats, waits for every predicted result and then lets the
  // block finish any beat that causes none.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (lens_cmds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes all five registers on consecutive edges. The count registers get
  // junk in the unused upper bits of the write data, which must be ignored.
  task automatic apply_settings(input cfg_t s);
    cfg_we    <= 1'b1;
    cfg_index <= REG_COARSE_STEP;
    cfg_wdata <= s.coarse_step;
    @(posedge clk);
    cfg_index <= REG_COARSE_COUNT;
    cfg_wdata <= {8'($urandom), s.coarse_count};
    @(posedge clk);
    cfg_index <= REG_FINE_STEP;
    cfg_wdata <= s.fine_step;
    @(posedge clk);
    cfg_index <= REG_FINE_COUNT;
    cfg_wdata <= {8'($urandom), s.fine_count};
    @(posedge clk);
    cfg_index <= REG_FOCUS_LIMIT;
    cfg_wdata <= s.focus_limit;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    lens_cfg = s;
    settings_used++;
  endtask

  // One complete search: a start, then statistics until the done command,
  // with an occasional restart thrown in and a stray beat before the start.
  task automatic one_search(input int restart_pct);
    bit dark_fine;
    dark_fine = ($urandom_range(0, 9) == 0);
    if ($urandom_range(0, 7) == 0) send_beat(1'b1, shaped_stats(1'b0));
    send_beat(1'b0, {144{1'b0}} | 144'($urandom));
    while (search_phase != PH_IDLE) begin
      if ($urandom_range(0, 99) < restart_pct) send_beat(1'b0, shaped_stats(1'b0));
      else send_beat(1'b1, shaped_stats(dark_fine));
    end
  endtask

  task automatic run_searches(input cfg_t s, input int unsigned budget,
                              input int restart_pct);
    int unsigned first;
    apply_settings(s);
    first = counted_beats;
    while (counted_beats - first < budget) one_search(restart_pct);
    wait_idle();
  endtask

  function automatic logic [15:0] edgy16();
    case ($urandom_range(0, 3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic cfg_t random_settings();
    cfg_t s;
    s.coarse_step  = edgy16();
    s.coarse_count = ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom_range(1, 8));
    s.fine_step    = edgy16();
    s.fine_count   = ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom_range(1, 8));
    s.focus_limit  = edgy16();
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // Hand-picked beats: a stray beat while idle, a restart in the coarse pass,
  // the largest step and clamp of the fine start at the focus limit, the fine
  // pass flooring at zero, a settle that stops on two close sums after a
  // miss, then all registers at zero with the largest statistics.
  task automatic test_directed_cases();
    cfg_t s;
    s.coarse_step  = 16'hFFFF;
    s.coarse_count = 8'd1;
    s.fine_step    = 16'hFFFF;
    s.fine_count   = 8'd1;
    s.focus_limit  = 16'hFFFF;
    apply_settings(s);
    send_beat(1'b1, {144{1'b1}});                         // dropped, nothing runs
    send_beat(1'b0, '0);
    send_beat(1'b1, '0);
    send_beat(1'b0, {144{1'b1}});                         // restart mid coarse pass
    send_beat(1'b1, pack_stats(1, 0, 0, 0, 0, 0));
    send_beat(1'b1, {144{1'b1}});                         // best at top, start clamps
    send_beat(1'b1, pack_stats(1000, 1000, 1000, 5, 6, 7));
    send_beat(1'b1, '0);                                  // fine focus floored at zero
    send_beat(1'b1, pack_stats(1000, 1000, 1000, 1, 2, 3)); // close, but first
    send_beat(1'b1, pack_stats(5000, 0, 0, 1, 2, 3));       // far off
    send_beat(1'b1, pack_stats(2800, 0, 0, 1, 2, 3));       // close after a miss
    send_beat(1'b1, pack_stats(3200, 0, 0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
    wait_idle();
    s = '0;
    apply_settings(s);
    send_beat(1'b0, '0);
    send_beat(1'b1, {144{1'b1}});                         // coarse done at once
    send_beat(1'b1, {144{1'b1}});                         // fine done at once
    send_beat(1'b1, {144{1'b1}});
    send_beat(1'b1, {144{1'b1}});                         // largest thresholds
    send_beat(1'b1, pack_stats(24'h000001, 0, 0, 0, 0, 0)); // idle again, dropped
    wait_idle();
  endtask

  task automatic test_reset_values();
    cfg_t s;
    s.coarse_step  = 16'd100;
    s.coarse_count = 8'd10;
    s.fine_step    = 16'd10;
    s.fine_count   = 8'd20;
    s.focus_limit  = 16'd1023;
    run_searches(s, 110, 2);
  endtask

  task automatic test_random_settings();
    repeat (8) run_searches(random_settings(), 45, 3);
  endtask

  // The longest coarse sweep at the largest step takes focus near the top of
  // its range. Restarts would throw away hundreds of beats, so none here.
  task automatic test_long_coarse_sweep();
    cfg_t s;
    s.coarse_step  = 16'hFFFF;
    s.coarse_count = 8'hFF;
    s.fine_step    = 16'd0;
    s.fine_count   = 8'd3;
    s.focus_limit  = 16'hFFFF;
    run_searches(s, 1, 0);
  endtask

  // The longest fine sweep, starting from up to 60010 and running into the zero floor.
  task automatic test_long_fine_sweep();
    cfg_t s;
    s.coarse_step  = 16'd60000;
    s.coarse_count = 8'd1;
    s.fine_step    = 16'd237;
    s.fine_count   = 8'hFF;
    s.focus_limit  = 16'hFFFF;
    run_searches(s, 1, 0);
  endtask

  initial begin
    reset_predictor();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_reset_values();
    test_random_settings();
    test_long_coarse_sweep();
    test_long_fine_sweep();
    wait_idle();
    $display("Covered %0d beats with results and %0d dropped beats under %0d settings.",
             counted_beats, ignored_beats, settings_used);
    $display("%0d searches reached done, %0d restarts, %0d result beats checked.",
             searches_done, restarts, beats_checked);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: random stalls, checking and the run limit.
  // --------------------------------------------------------------------------

  // The ready line holds each value for a random span; calm stretches keep
  // it high so that results also leave back to back.
  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      out_tready <= out_calm || ($urandom_range(0, 2) != 0);
      ready_hold <= idle_span();
      if ($urandom_range(0, 31) == 0) out_calm <= !out_calm;
    end
  end

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("Mismatch in result beat %0d, %s: got 0x%0h, expected 0x%0h",
             beats_checked, what, got, want);
    err_count++;
  endtask

  result_t want_beat;

  // Inputs and outputs are read just after the edge, before the block's
  // registers update, so these are the values the edge itself sampled.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      beats_checked++;
      if (lens_cmds.size() == 0) begin
        report_mismatch("beat with none expected, command", out_tuser, 0);
      end else begin
        want_beat = lens_cmds.pop_front();
        if (out_tuser !== want_beat.cmd)
          report_mismatch("command", out_tuser, want_beat.cmd);
        if (out_tdata[23:0] !== want_beat.focus)
          report_mismatch("focus", out_tdata[23:0], want_beat.focus);
        if (out_tdata[48:24] !== want_beat.sharp_threshold)
          report_mismatch("sharp_threshold", out_tdata[48:24], want_beat.sharp_threshold);
        if (out_tdata[70:49] !== want_beat.lum_threshold)
          report_mismatch("lum_threshold", out_tdata[70:49], want_beat.lum_threshold);
        if (out_tdata[71] !== 1'b0)
          report_mismatch("pad bit", out_tdata[71], 0);
        if (out_tlast !== want_beat.last)
          report_mismatch("last", out_tlast, want_beat.last);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, lens_cmds.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    counted_beats = 0;
    ignored_beats = 0;
    searches_done = 0;
    restarts      = 0;
    settings_used = 0;
    beats_checked = 0;
    err_count     = 0;
    cycle_count   = 0;
  end

endmodule
